@@ design/aes_pkg.sv @@
// aes_pkg: shared types, s-box and round helpers for the aes-128 pipeline
// no dependencies
`timescale 1ns / 1ps
package aes_pkg;

    localparam int unsigned HALF_W = 64;
    localparam int unsigned BLOCK_W = 128;
    localparam int unsigned ROUNDS = 10;
    localparam int unsigned CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } t_cfg_reg;

    typedef logic [BLOCK_W-1:0] t_block;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [ROUNDS] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    // byte n of a block sits at bits 127-8n
    function automatic logic [7:0] get_byte(input t_block b, input int unsigned n);
        get_byte = b[BLOCK_W-1-8*n -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // subbytes + shiftrows
    function automatic t_block sub_shift(input t_block s);
        t_block o;
        o = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                o[BLOCK_W-1-8*(r+4*c) -: 8] = SBOX[get_byte(s, r + 4*((c + r) % 4))];
            end
        end
        sub_shift = o;
    endfunction

    function automatic t_block mix_cols(input t_block s);
        t_block o;
        logic [7:0] a0, a1, a2, a3, all;
        o = '0;
        for (int c = 0; c < 4; c++) begin
            a0  = get_byte(s, 4*c);
            a1  = get_byte(s, 4*c+1);
            a2  = get_byte(s, 4*c+2);
            a3  = get_byte(s, 4*c+3);
            all = a0 ^ a1 ^ a2 ^ a3;
            o[BLOCK_W-1-8*(4*c)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            o[BLOCK_W-1-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            o[BLOCK_W-1-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            o[BLOCK_W-1-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        mix_cols = o;
    endfunction

    // next round key from the previous one; rnd counts from 0
    function automatic t_block next_key(input t_block k, input int unsigned rnd);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {SBOX[w3[23:16]] ^ RCON[rnd], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        next_key = {w0, w1, w2, w3};
    endfunction

endpackage

@@ design/aes_stream_if.sv @@
// aes_stream_if: valid/ready channel carrying one 128-bit block as two halves
// depends on aes_pkg
`timescale 1ns / 1ps
interface aes_stream_if;
    logic                       valid;
    logic                       ready;
    logic [aes_pkg::HALF_W-1:0] data_high;
    logic [aes_pkg::HALF_W-1:0] data_low;

    modport source (output valid, output data_high, output data_low, input ready);
    modport sink   (input valid, input data_high, input data_low, output ready);
endinterface

@@ design/aes128_block_encrypt.sv @@
// aes128_block_encrypt: pipelined aes-128 encryption, one round per stage
// depends on aes_pkg and aes_stream_if
//
//   channel   dir  width        handshake
//   s_in      in   2 x 64 bit   valid/ready, plaintext word
//   m_out     out  2 x 64 bit   valid/ready, ciphertext word
//   cfg       in   idx 1, 64    write enable, key_high / key_low
//
// eleven register stages (add-key stage plus ten round stages), one word per cycle while m_out is not stalled
// a word accepted into the add-key stage passes through the round stages in order and leaves on m_out
// each stage but the last carries its word's round key, from which the next stage's key is derived,
// so a word accepted right after a key write already uses the new key
// stalls freeze the whole pipe; ready = output slot free or m_out ready
// reset (sync, active low) clears valid bits and the key
`timescale 1ns / 1ps
module aes128_block_encrypt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [aes_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [aes_pkg::HALF_W-1:0]    i_cfg_data,
    aes_stream_if.sink                    s_in,
    aes_stream_if.source                  m_out
);
    import aes_pkg::*;

    // key registers
    logic [HALF_W-1:0] r_key_high, r_key_low;
    // r_rk[i] is round key i of the word held in stage i
    t_block            r_rk [ROUNDS];
    // n_rk[i] is round key i, derived from the key of the stage before
    t_block            n_rk [1:ROUNDS];

    // pipeline: stage 0 holds state after initial add-key, stage i after round i
    t_block            r_st [ROUNDS+1];
    logic [ROUNDS:0]   r_vld;
    logic              advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_KEY_HIGH: r_key_high <= i_cfg_data;
                REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // one key schedule step per stage, alongside the round
    always_comb begin
        for (int i = 1; i <= ROUNDS; i++) begin
            n_rk[i] = next_key(r_rk[i-1], i - 1);
        end
    end

    // whole pipe moves unless the last stage holds an untaken word
    assign advance     = !r_vld[ROUNDS] || m_out.ready;
    assign s_in.ready  = advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (advance) begin
            r_vld <= {r_vld[ROUNDS-1:0], s_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_rk[0] <= {r_key_high, r_key_low};
            r_st[0] <= {s_in.data_high, s_in.data_low} ^ {r_key_high, r_key_low};
            for (int i = 1; i < ROUNDS; i++) begin
                r_rk[i] <= n_rk[i];
                r_st[i] <= mix_cols(sub_shift(r_st[i-1])) ^ n_rk[i];
            end
            // final round skips mixcolumns
            r_st[ROUNDS] <= sub_shift(r_st[ROUNDS-1]) ^ n_rk[ROUNDS];
        end
    end

    assign m_out.valid     = r_vld[ROUNDS];
    assign m_out.data_high = r_st[ROUNDS][BLOCK_W-1:HALF_W];
    assign m_out.data_low  = r_st[ROUNDS][HALF_W-1:0];

endmodule

@@ design/aes_checker.sv @@
// aes_checker: port-level checks on the aes-128 pipeline, bound to aes128_block_encrypt
// depends on aes_pkg and, through the bind, on aes128_block_encrypt and aes_stream_if
`timescale 1ns / 1ps
module aes_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [aes_pkg::HALF_W-1:0] i_out_high
);
    import aes_pkg::*;

    // ready follows directly from the output slot
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready) else $error("input stalled with empty output");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !i_in_ready) else $error("input taken during stall");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_high)))
        else $error("stalled word changed");

    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid) else $error("word after reset");
endmodule

bind aes128_block_encrypt aes_checker u_aes_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_ready (s_in.ready),
    .i_out_valid(m_out.valid),
    .i_out_ready(m_out.ready),
    .i_out_high (m_out.data_high)
);

@@ tb/aes128_block_encrypt_test.sv @@
// aes128_block_encrypt_test: self-checking bench for the aes-128 encryption pipeline
// depends on aes_pkg, aes_stream_if and aes128_block_encrypt
`timescale 1ns / 1ps
module aes128_block_encrypt_test;
    import aes_pkg::*;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } t_half_pair;

    // one row of the directed table; has_ct marks a typed-in ciphertext
    typedef struct {
        logic        set_key;
        logic [63:0] khi;
        logic [63:0] klo;
        t_half_pair  pt;
        logic        has_ct;
        t_half_pair  ct;
    } t_dir_row;

    localparam int LATENCY   = 11;
    localparam int WDOG_MAX  = 2000;
    localparam int N_RANDOM  = 1600;
    localparam int N_PHASES  = 6;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [HALF_W-1:0] i_cfg_data = '0;

    aes_stream_if s_in();
    aes_stream_if m_out();

    aes128_block_encrypt uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_in       (s_in.sink),
        .m_out      (m_out.source)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor's own copy of the key registers
    logic [63:0] key_hi_shadow = '0;
    logic [63:0] key_lo_shadow = '0;

    t_half_pair cipher_q[$];
    int n_mismatch = 0;
    int idle_cycles = 0;
    bit no_idle = 1'b0;     // last part of the run: no gaps on either side
    bit hold_rx = 1'b0;     // long receiver hold-off requested
    bit timed_out = 1'b0;

    // ---------------- predictor ----------------
    logic [7:0] sb_tab [256];
    initial begin
        logic [7:0] inv, p, q, x;
        for (int v = 0; v < 256; v++) begin
            // multiplicative inverse in gf(2^8) by brute search, then the affine map
            inv = 8'h00;
            for (int u = 1; u < 256; u++) begin
                p = 8'h00;
                q = u[7:0];
                for (int b = 0; b < 8; b++) begin
                    if (v[b]) p = p ^ q;
                    q = {q[6:0], 1'b0} ^ (q[7] ? 8'h1b : 8'h00);
                end
                if (p == 8'h01) inv = u[7:0];
            end
            x = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sb_tab[v] = x;
        end
    end

    function automatic logic [7:0] gf_dbl(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic t_half_pair predict_cipher(input t_half_pair pt,
                                                  input logic [63:0] khi,
                                                  input logic [63:0] klo);
        logic [7:0] ks [176];
        logic [7:0] st [16];
        logic [7:0] tmp [16];
        logic [7:0] t [4];
        logic [7:0] first, a0, a1, a2, a3, all, rc;
        t_half_pair res;
        for (int n = 0; n < 8; n++) begin
            ks[n]     = khi[63-8*n -: 8];
            ks[n+8]   = klo[63-8*n -: 8];
            st[n]     = pt.hi[63-8*n -: 8];
            st[n+8]   = pt.lo[63-8*n -: 8];
        end
        rc = 8'h01;
        for (int w = 4; w < 44; w++) begin
            for (int b = 0; b < 4; b++) t[b] = ks[4*(w-1)+b];
            if (w % 4 == 0) begin
                first = t[0];
                t[0] = sb_tab[t[1]] ^ rc;
                t[1] = sb_tab[t[2]];
                t[2] = sb_tab[t[3]];
                t[3] = sb_tab[first];
                rc = gf_dbl(rc);
            end
            for (int b = 0; b < 4; b++) ks[4*w+b] = ks[4*(w-4)+b] ^ t[b];
        end
        for (int n = 0; n < 16; n++) st[n] = st[n] ^ ks[n];
        for (int rnd = 1; rnd <= 10; rnd++) begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    tmp[r+4*c] = sb_tab[st[r + 4*((c+r) % 4)]];
            st = tmp;
            if (rnd < 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    st[4*c]   = a0 ^ all ^ gf_dbl(a0 ^ a1);
                    st[4*c+1] = a1 ^ all ^ gf_dbl(a1 ^ a2);
                    st[4*c+2] = a2 ^ all ^ gf_dbl(a2 ^ a3);
                    st[4*c+3] = a3 ^ all ^ gf_dbl(a3 ^ a0);
                end
            end
            for (int n = 0; n < 16; n++) st[n] = st[n] ^ ks[16*rnd+n];
        end
        for (int n = 0; n < 8; n++) begin
            res.hi[63-8*n -: 8] = st[n];
            res.lo[63-8*n -: 8] = st[n+8];
        end
        return res;
    endfunction

    // ---------------- drive helpers ----------------
    task automatic write_key_reg(input t_cfg_reg idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == REG_KEY_HIGH) key_hi_shadow = val;
        else key_lo_shadow = val;
    endtask

    task automatic load_key(input logic [63:0] khi, input logic [63:0] klo);
        write_key_reg(REG_KEY_HIGH, khi);
        write_key_reg(REG_KEY_LOW, klo);
        // quiet cycles before the next word
        repeat (3) @(negedge i_clk);
    endtask

    // block is idle: every expected word back, plus margin
    task automatic wait_drained();
        while (cipher_q.size() != 0 && !timed_out) @(negedge i_clk);
        repeat (LATENCY + 2) @(negedge i_clk);
    endtask

    // offer one word; called at a falling edge, returns at the falling edge after accept
    task automatic push_word(input t_half_pair pt, input logic has_ct,
                             input t_half_pair ct);
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            s_in.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        s_in.valid     <= 1'b1;
        s_in.data_high <= pt.hi;
        s_in.data_low  <= pt.lo;
        do @(posedge i_clk); while (!s_in.ready && !timed_out);
        cipher_q.push_back(has_ct ? ct : predict_cipher(pt, key_hi_shadow, key_lo_shadow));
        @(negedge i_clk);
    endtask

    // ---------------- receiver ----------------
    initial begin
        m_out.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_rx) begin
                m_out.ready <= 1'b0;
                repeat (60) @(negedge i_clk);
                hold_rx = 1'b0;
                m_out.ready <= 1'b1;
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
                m_out.ready <= 1'b0;
                repeat ($urandom_range(1, 12) - 1) @(negedge i_clk);
            end else begin
                m_out.ready <= 1'b1;
            end
        end
    end

    // checker and the watchdog's idle counter run on the rising edge
    always @(posedge i_clk) begin
        t_half_pair want;
        if (i_rst_n) begin
            if (m_out.valid && m_out.ready) begin
                if (cipher_q.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("unexpected ciphertext word %h %h",
                                 m_out.data_high, m_out.data_low);
                end else begin
                    want = cipher_q.pop_front();
                    if (m_out.data_high !== want.hi || m_out.data_low !== want.lo) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("ciphertext mismatch: expected %h %h got %h %h",
                                     want.hi, want.lo, m_out.data_high, m_out.data_low);
                    end
                end
            end
            if ((m_out.valid && m_out.ready) || (s_in.valid && s_in.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(negedge i_clk) begin
        if (idle_cycles >= WDOG_MAX) begin
            timed_out = 1'b1;
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    t_dir_row dir_rows [$];

    function automatic t_dir_row mk_row(input logic set_key, input logic [63:0] khi,
                                        input logic [63:0] klo, input logic [63:0] phi,
                                        input logic [63:0] plo, input logic has_ct,
                                        input logic [63:0] chi, input logic [63:0] clo);
        t_dir_row r;
        r.set_key = set_key; r.khi = khi; r.klo = klo;
        r.pt = '{phi, plo}; r.has_ct = has_ct; r.ct = '{chi, clo};
        return r;
    endfunction

    initial begin
        t_half_pair pt, none;
        int sel;
        none = '0;
        s_in.valid = 1'b0;
        s_in.data_high = '0;
        s_in.data_low = '0;

        // key never written: all-zero key, zero block gives the known vector
        dir_rows.push_back(mk_row(1'b0, 64'h0, 64'h0, 64'h0, 64'h0,
                                  1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e));
        dir_rows.push_back(mk_row(1'b0, 64'h0, 64'h0, '1, '1, 1'b0, 64'h0, 64'h0));
        dir_rows.push_back(mk_row(1'b0, 64'h0, 64'h0, 64'h8000000000000000, 64'h1,
                                  1'b0, 64'h0, 64'h0));
        // standard vectors with the textbook keys
        dir_rows.push_back(mk_row(1'b1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                                  64'h0011223344556677, 64'h8899aabbccddeeff,
                                  1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a));
        dir_rows.push_back(mk_row(1'b1, 64'h2b7e151628aed2a6, 64'habf7158809cf4f3c,
                                  64'h3243f6a8885a308d, 64'h313198a2e0370734,
                                  1'b1, 64'h3925841d02dc09fb, 64'hdc118597196a0b32));
        // extreme keys
        dir_rows.push_back(mk_row(1'b1, '1, '1, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0));
        dir_rows.push_back(mk_row(1'b0, 64'h0, 64'h0, '1, '1, 1'b0, 64'h0, 64'h0));
        dir_rows.push_back(mk_row(1'b0, 64'h0, 64'h0, 64'haaaaaaaaaaaaaaaa,
                                  64'h5555555555555555, 1'b0, 64'h0, 64'h0));
        dir_rows.push_back(mk_row(1'b1, '1, 64'h0, 64'h0123456789abcdef, '1,
                                  1'b0, 64'h0, 64'h0));
        dir_rows.push_back(mk_row(1'b1, 64'h0, '1, 64'hfedcba9876543210, 64'h0,
                                  1'b0, 64'h0, 64'h0));
        dir_rows.push_back(mk_row(1'b1, 64'h0, 64'h0, 64'h0, 64'h0,
                                  1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e));

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        foreach (dir_rows[i]) begin
            if (dir_rows[i].set_key) begin
                s_in.valid <= 1'b0;
                wait_drained();
                load_key(dir_rows[i].khi, dir_rows[i].klo);
            end
            push_word(dir_rows[i].pt, dir_rows[i].has_ct, dir_rows[i].ct);
        end

        // random phases, each with a new key; extremes among them
        for (int ph = 0; ph < N_PHASES; ph++) begin
            s_in.valid <= 1'b0;
            wait_drained();
            case (ph)
                0: load_key('1, '1);
                1: load_key('0, '0);
                default: load_key({$urandom, $urandom}, {$urandom, $urandom});
            endcase
            if (ph == 2) hold_rx = 1'b1;
            if (ph == N_PHASES - 1) no_idle = 1'b1;
            for (int k = 0; k < N_RANDOM / N_PHASES; k++) begin
                sel = $urandom_range(0, 15);
                pt.hi = {$urandom, $urandom};
                pt.lo = {$urandom, $urandom};
                if (sel == 0) pt = '0;
                else if (sel == 1) pt = '1;
                else if (sel == 2) pt.hi = '1;
                push_word(pt, 1'b0, none);
                // sender pause until everything is back
                if (ph == 3 && k == 100) begin
                    s_in.valid <= 1'b0;
                    while (cipher_q.size() != 0 && !timed_out) @(negedge i_clk);
                end
            end
        end

        s_in.valid <= 1'b0;
        while (cipher_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
        if (n_mismatch == 0 && cipher_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
